FILE: sv/sld_pkg.sv
// Shared types and constants for the sync/length/body deframer.
package sld_pkg;

  // Sync pair and length field size
  localparam logic [7:0] SYNC_FIRST  = 8'h59;  // 'Y'
  localparam logic [7:0] SYNC_SECOND = 8'h48;  // 'H'
  localparam int unsigned LEN_BYTES  = 4;
  localparam int unsigned SYNC_BYTES = 2;

  localparam int unsigned MAX_LEN_W = 31;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 31'd65536;

  // Byte position inside the sync pair or the length field
  localparam logic [1:0] IDX_FIRST = 2'(0);
  localparam logic [1:0] IDX_SYNC2 = 2'(SYNC_BYTES - 1);
  localparam logic [1:0] IDX_LAST  = 2'(LEN_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // One result from the frame logic
  typedef struct packed {
    logic       vld;
    kind_e      kind;
    logic [7:0] body_byte;
    logic       last;
  } sld_res_t;

endpackage

FILE: sv/sync_length_body_deframer_core.sv
// A byte passes from the input register through the frame logic into the result register once that register has room.
// Throughput: one byte per cycle while the consumer takes results; the whole frame state
// update is one register-to-register step between the input register and the result register.
// Reset (rst_ni low, asynchronous): both stages empty, hunting for sync,
// length and body counters cleared, max_body_length back to 65536.
module sync_length_body_deframer_core import sld_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           body_byte_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [MAX_LEN_W-1:0] cfg_max_body_length_i
);

  logic [MAX_LEN_W-1:0] max_len_q;
  logic                 s1_vld, step, out_free;
  logic [7:0]           s1_byte;
  sld_res_t             res;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_max_body_length_i;
    end
  end

  // Byte moves through the frame logic when the result slot has room
  assign step = s1_vld && out_free;

  sld_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .take_i     (step),
    .vld_o      (s1_vld),
    .byte_o     (s1_byte)
  );

  sld_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (s1_byte),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  sld_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .body_byte_o (body_byte_o),
    .last_o      (last_o)
  );

endmodule

FILE: sv/sld_in_stage.sv
// Input register: holds one received byte until the frame logic takes it.
module sld_in_stage import sld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       accept;

  // Free when empty or when the held byte leaves this cycle
  assign in_ready_o = !vld_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

FILE: sv/sld_frame_fsm.sv
// Frame state machine: sync hunt, length collection and body pass-through.
module sld_frame_fsm import sld_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic [MAX_LEN_W-1:0] max_len_i,
  output sld_res_t             res_o
);

  phase_e               phase_q, phase_d;
  logic [1:0]           idx_q, idx_d;
  logic                 first_q, first_d;
  logic [23:0]          len_q, len_d;
  logic [MAX_LEN_W-1:0] rem_q, rem_d;

  logic [MAX_LEN_W-1:0] len_full;
  logic                 len_neg, len_big, len_zero, len_done, rem_end;

  // Length as seen on the final length byte
  assign len_full = {byte_i[6:0], len_q};
  assign len_neg  = byte_i[7];
  assign len_big  = len_full > max_len_i;
  assign len_zero = (len_full == '0) && !len_neg;
  assign len_done = (idx_q == IDX_LAST);
  assign rem_end  = (rem_q <= MAX_LEN_W'(1));

  // Next state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    first_d = first_q;
    len_d   = len_q;
    rem_d   = rem_q;
    case (phase_q)
      PH_LENGTH: begin
        idx_d = idx_q + 2'd1;
        case (idx_q)
          2'd0:    len_d[7:0]   = byte_i;
          2'd1:    len_d[15:8]  = byte_i;
          2'd2:    len_d[23:16] = byte_i;
          default: len_d        = len_q;
        endcase
        if (len_done) begin
          if (len_neg || len_big || len_zero) begin
            phase_d = PH_HUNT;
            first_d = 1'b0;
          end else begin
            phase_d = PH_BODY;
            rem_d   = len_full;
          end
        end
      end
      PH_BODY: begin
        if (rem_end) begin
          rem_d   = '0;
          phase_d = PH_HUNT;
          idx_d   = IDX_FIRST;
          first_d = 1'b0;
        end else begin
          rem_d = rem_q - MAX_LEN_W'(1);
        end
      end
      default: begin
        // Hunt, also any unused phase code; pairs are taken whole
        phase_d = PH_HUNT;
        if (idx_q == IDX_FIRST) begin
          first_d = (byte_i == SYNC_FIRST);
          idx_d   = IDX_SYNC2;
        end else begin
          if (first_q && (byte_i == SYNC_SECOND)) begin
            phase_d = PH_LENGTH;
          end
          idx_d   = IDX_FIRST;
          first_d = 1'b0;
        end
      end
    endcase
  end

  // Result for the current byte
  always_comb begin
    res_o           = '0;
    res_o.kind      = KIND_BODY;
    case (phase_q)
      PH_LENGTH: begin
        if (len_done) begin
          if (len_neg || len_big) begin
            res_o.vld  = 1'b1;
            res_o.kind = KIND_REJECT;
          end else if (len_zero) begin
            res_o.vld  = 1'b1;
            res_o.kind = KIND_EMPTY;
            res_o.last = 1'b1;
          end
        end
      end
      PH_BODY: begin
        res_o.vld       = 1'b1;
        res_o.kind      = KIND_BODY;
        res_o.body_byte = byte_i;
        res_o.last      = rem_end;
      end
      default: begin
        res_o.vld = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= IDX_FIRST;
      first_q <= 1'b0;
      len_q   <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      first_q <= first_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

FILE: sv/sld_out_stage.sv
// Result register: holds one result until the consumer takes it.
module sld_out_stage import sld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  sld_res_t   res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] body_byte_o,
  output logic       last_o
);

  logic       vld_q, vld_d;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Room for a new result when empty or being drained
  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    if (load_i) begin
      vld_d = res_i.vld;
    end else begin
      vld_d = vld_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.vld) begin
      kind_q <= res_i.kind;
      byte_q <= res_i.body_byte;
      last_q <= res_i.last;
    end
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign body_byte_o = byte_q;
  assign last_o      = last_q;

endmodule

FILE: sv/sld_checker.sv
// Port-level checks for the deframer, bound to the top level.
module sld_port_checks import sld_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] body_byte_o,
  input logic       last_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(body_byte_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_BODY) || (kind_o == KIND_EMPTY)
      || (kind_o == KIND_REJECT))
    else $error("unused result kind");

  // Rejection never closes a frame, an empty frame always does
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_BODY) |-> last_o == (kind_o == KIND_EMPTY))
    else $error("last flag wrong for kind");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_BODY) |-> body_byte_o == 8'h00)
    else $error("data on a non-body result");

endmodule

bind sync_length_body_deframer_core sld_port_checks u_sld_port_checks (.*);
